[hdl/smav_pkg.sv]
// smav_pkg: shared widths, types and controller states for the moving-average block
// no dependencies; compile first

package smav_pkg;

  // field widths
  localparam int SampleW = 16;
  localparam int CntW    = 7;
  localparam int FracW   = 8;
  localparam int MeanW   = 24;

  // running sum holds up to 127 full-scale samples
  localparam int SumW  = SampleW + CntW;
  localparam int DivW  = SumW + FracW;
  localparam int StepW = $clog2(DivW);

  localparam int CntMax           = (1 << CntW) - 1;
  localparam int MaxWindowDefault = 64;

  typedef logic signed [SampleW-1:0] sample_t;
  typedef logic signed [MeanW-1:0]   mean_t;
  typedef logic        [CntW-1:0]    count_t;
  typedef logic signed [SumW-1:0]    sum_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_DIV,
    ST_DONE
  } smav_state_t;

endpackage

[hdl/smav_sample_if.sv]
// smav_sample_if: valid/ready channel carrying one input sample word
// depends on smav_pkg

interface smav_sample_if;
  import smav_pkg::*;

  logic    valid;
  logic    ready;
  sample_t sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

[hdl/smav_result_if.sv]
// smav_result_if: valid/ready channel carrying one mean result word
// depends on smav_pkg

interface smav_result_if;
  import smav_pkg::*;

  logic   valid;
  logic   ready;
  mean_t  mean_q8;
  count_t held_count;

  modport source (output valid, output mean_q8, output held_count, input ready);
  modport sink   (input valid, input mean_q8, input held_count, output ready);
endinterface

[hdl/sliding_window_moving_average.sv]
// sliding_window_moving_average: sample ring in one synchronous ram, running sum and Q8 mean
// a result word passes the ram read state, the divider state and the done state before it is valid
// one sample in flight: the next is taken only once the last has left the 31-step restoring divider
// the output register lets the next sample in while a result still waits
// reset: synchronous, window 1, sum, fill count and pointer cleared; ram left as is
// depends on smav_pkg, smav_sample_if, smav_result_if

module sliding_window_moving_average #(
  parameter int MAX_WINDOW = smav_pkg::MaxWindowDefault
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_wr_en,
  input  logic [smav_pkg::CntW-1:0]  cfg_wr_data,
  smav_sample_if.sink                sample_ch,
  smav_result_if.source              result_ch
);
  import smav_pkg::*;

  localparam int PtrW   = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int WinCap = (MAX_WINDOW > CntMax) ? CntMax : MAX_WINDOW;

  // control state
  smav_state_t     state, state_next;
  count_t          win_eff;
  count_t          fill_cnt;
  logic [PtrW-1:0] ptr;
  sum_t            run_sum;
  logic [StepW-1:0] step;
  logic            res_valid;

  // payload
  sample_t         samp;
  logic            is_full;
  sample_t         rd_data;
  logic [DivW-1:0] dq;
  count_t          rem;
  logic            neg;
  mean_t           res_mean;
  count_t          res_cnt;

  // sample ring
  sample_t ring [MAX_WINDOW];

  logic            accept;
  logic            res_load;
  logic [PtrW-1:0] wr_slot;
  sum_t            sum_drop;
  sum_t            sum_new;
  count_t          cnt_new;
  logic [SumW-1:0] sum_mag;
  logic [PtrW-1:0] ptr_adv;
  logic [CntW:0]   rem_sh;
  logic [CntW:0]   rem_diff;
  logic            q_bit;
  logic [MeanW-1:0] q_mag;
  count_t          cfg_win;

  // next state and handshakes
  always_comb begin
    state_next = state;
    sample_ch.ready = 1'b0;
    res_load = 1'b0;
    case (state)
      ST_IDLE: begin
        sample_ch.ready = 1'b1;
        if (sample_ch.valid) state_next = ST_READ;
      end
      ST_READ: state_next = ST_DIV;
      ST_DIV: begin
        if (step == '0) state_next = ST_DONE;
      end
      ST_DONE: begin
        if (!res_valid || result_ch.ready) begin
          res_load = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign accept = sample_ch.valid && sample_ch.ready;

  // window length: zero reads as one, large values saturate
  always_comb begin
    cfg_win = cfg_wr_data;
    if (cfg_wr_data == '0) cfg_win = count_t'(1);
    else if (int'(cfg_wr_data) > WinCap) cfg_win = count_t'(WinCap);
  end

  // read-modify-write of the running sum; ring read data arrived this cycle
  always_comb begin
    sum_drop = is_full ? (run_sum - sum_t'(rd_data)) : run_sum;
    sum_new  = sum_drop + sum_t'(samp);
    cnt_new  = is_full ? fill_cnt : (fill_cnt + count_t'(1));
    sum_mag  = sum_new[SumW-1] ? (-sum_new) : sum_new;
    wr_slot  = is_full ? ptr : PtrW'(fill_cnt);
    ptr_adv  = (int'(ptr) + 1 >= int'(win_eff)) ? '0 : (ptr + PtrW'(1));
  end

  // one restoring divide step per cycle, divisor is the fill count
  always_comb begin
    rem_sh   = {rem, dq[DivW-1]};
    rem_diff = rem_sh - {1'b0, fill_cnt};
    q_bit    = (rem_sh >= {1'b0, fill_cnt});
    q_mag    = dq[MeanW-1:0];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      win_eff   <= count_t'(1);
      fill_cnt  <= '0;
      ptr       <= '0;
      run_sum   <= '0;
      step      <= '0;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_wr_en) begin
        win_eff  <= cfg_win;
        fill_cnt <= '0;
        ptr      <= '0;
        run_sum  <= '0;
      end else if (state == ST_READ) begin
        run_sum  <= sum_new;
        fill_cnt <= cnt_new;
        if (is_full) ptr <= ptr_adv;
      end
      if (state == ST_READ) step <= StepW'(DivW - 1);
      else if (state == ST_DIV) step <= step - StepW'(1);
      if (res_load) res_valid <= 1'b1;
      else if (result_ch.ready) res_valid <= 1'b0;
    end
  end

  // ram: one item in flight, so the read never overlaps a pending write
  always_ff @(posedge clk) begin
    if (accept) rd_data <= ring[ptr];
    if (state == ST_READ) ring[wr_slot] <= samp;
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      samp    <= sample_ch.sample;
      is_full <= (fill_cnt == win_eff);
    end
    if (state == ST_READ) begin
      dq  <= {sum_mag, {FracW{1'b0}}};
      rem <= '0;
      neg <= sum_new[SumW-1];
    end else if (state == ST_DIV) begin
      dq  <= {dq[DivW-2:0], q_bit};
      rem <= q_bit ? rem_diff[CntW-1:0] : rem_sh[CntW-1:0];
    end
    if (res_load) begin
      res_mean <= neg ? mean_t'(-q_mag) : mean_t'(q_mag);
      res_cnt  <= fill_cnt;
    end
  end

  assign result_ch.valid      = res_valid;
  assign result_ch.mean_q8    = res_mean;
  assign result_ch.held_count = res_cnt;

`ifndef SYNTHESIS
  // fill count never runs past the window
  a_fill_in_window: assert property (@(posedge clk) disable iff (rst)
    fill_cnt <= win_eff)
    else $error("fill count above window length");

  // oldest pointer stays inside the window
  a_ptr_in_window: assert property (@(posedge clk) disable iff (rst)
    int'(ptr) < int'(win_eff))
    else $error("oldest pointer outside window");

  // an accepted word goes straight to the ram read cycle
  a_accept_to_read: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == ST_READ)
    else $error("accepted word did not start a ram read");

  // the divider finishes after its last step
  a_div_ends: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV && step == '0) |=> state == ST_DONE)
    else $error("divider did not finish on its last step");

  // a result word always covers at least one sample
  a_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> res_cnt != '0)
    else $error("result word with zero held count");
`endif

endmodule

[tb/sliding_window_moving_average_test.sv]
// sliding_window_moving_average_test: self-checking bench for the moving-average block
// predicts each Q8 mean and held count in step with the accepted sample words
// depends on smav_pkg, smav_sample_if, smav_result_if and sliding_window_moving_average
`timescale 1ns / 1ps

module sliding_window_moving_average_test;
  import smav_pkg::*;

  localparam int WindowMax  = MaxWindowDefault;
  localparam int CycleLimit = 500000;
  localparam int HoldCycles = 300;
  localparam int SettleWait = 40;

  typedef struct {
    mean_t  mean_q8;
    count_t held_count;
  } mean_word_t;

  logic   clk;
  logic   rst;
  logic   cfg_wr_en;
  count_t cfg_wr_data;

  smav_sample_if sample_ch ();
  smav_result_if result_ch ();

  sliding_window_moving_average DUT (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .sample_ch  (sample_ch),
    .result_ch  (result_ch)
  );

  // predictor state: window register, sample history, sum, fill and oldest slot
  count_t     window_reg;
  sample_t    hist_ring [WindowMax];
  sum_t       hist_sum;
  count_t     hist_fill;
  logic [5:0] hist_oldest;

  mean_word_t pending_means [$];
  int         failures;
  int         cycle_count;
  bit         idle_on;
  bit         hold_req;
  int         run_left;
  sample_t    run_val;

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // runaway guard
  initial begin
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb: failure");
    $finish;
  end

  // mean of the held samples after taking in one new sample
  task automatic predict_mean(input sample_t s, output mean_t m, output count_t c);
    int     w;
    int     slot;
    longint scaled;
    w = (window_reg == 0) ? 1 : ((window_reg > WindowMax) ? WindowMax : int'(window_reg));
    if (hist_oldest >= w) hist_oldest = '0;
    if (hist_fill > w) hist_fill = count_t'(w);
    if (hist_fill == w) begin
      // full: oldest sample leaves, new one takes its slot
      slot = hist_oldest;
      hist_sum = hist_sum - hist_ring[slot];
      hist_oldest = (slot + 1 >= w) ? 6'd0 : 6'(slot + 1);
    end else begin
      slot = hist_oldest + hist_fill;
      if (slot >= w) slot -= w;
      hist_fill++;
    end
    hist_ring[slot] = s;
    hist_sum = hist_sum + s;
    scaled = longint'(hist_sum) * 256;
    m = mean_t'(scaled / longint'(hist_fill));
    c = hist_fill;
  endtask

  // offer one sample word, record its expected mean once accepted
  task automatic send_sample(input sample_t s);
    mean_word_t exp_word;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      sample_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    sample_ch.valid  <= 1'b1;
    sample_ch.sample <= s;
    @(posedge clk);
    while (!sample_ch.ready) @(posedge clk);
    predict_mean(s, exp_word.mean_q8, exp_word.held_count);
    pending_means.push_back(exp_word);
  endtask

  // let every mean word out, with no sample on offer
  task automatic drain_means();
    sample_ch.valid <= 1'b0;
    while (pending_means.size() != 0) @(posedge clk);
  endtask

  // window write only once the block is idle; clears the history
  task automatic write_window(input count_t len);
    drain_means();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= len;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    window_reg  = len;
    hist_sum    = '0;
    hist_fill   = '0;
    hist_oldest = '0;
  endtask

  // random sample: mostly full range, some small, extremes and long constant runs
  function automatic sample_t random_sample();
    if (run_left > 0) begin
      run_left--;
      return run_val;
    end
    case ($urandom_range(0, 9))
      0: begin
        run_val  = ($urandom_range(0, 1) == 0) ? 16'sh7fff : 16'sh8000;
        run_left = $urandom_range(10, 70);
        return run_val;
      end
      1: begin
        case ($urandom_range(0, 4))
          0: return 16'sh7fff;
          1: return 16'sh8000;
          2: return 16'sh0000;
          3: return 16'shffff;
          default: return 16'sh0001;
        endcase
      end
      2, 3: return sample_t'($urandom_range(0, 255) - 128);
      default: return sample_t'($urandom());
    endcase
  endfunction

  // result side: ready bursts, long hold on request, check each word
  initial begin
    int         stall_left;
    int         hold_left;
    mean_word_t exp_word;
    stall_left = 0;
    hold_left  = 0;
    forever begin
      @(posedge clk);
      if (result_ch.valid && result_ch.ready) begin
        if (pending_means.size() == 0) begin
          $error("unexpected mean word: mean_q8 %0d, held_count %0d",
                 result_ch.mean_q8, result_ch.held_count);
          failures++;
        end else begin
          exp_word = pending_means.pop_front();
          if (result_ch.mean_q8 !== exp_word.mean_q8) begin
            $error("mean_q8 mismatch: expected %0d, actual %0d",
                   exp_word.mean_q8, result_ch.mean_q8);
            failures++;
          end
          if (result_ch.held_count !== exp_word.held_count) begin
            $error("held_count mismatch: expected %0d, actual %0d",
                   exp_word.held_count, result_ch.held_count);
            failures++;
          end
        end
      end
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        result_ch.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        stall_left = $urandom_range(1, 11) - 1;
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= 1'b1;
      end
    end
  end

  // reset window of one, extremes each on their own
  task automatic test_reset_window();
    send_sample(16'sh7fff);
    send_sample(16'sh8000);
    send_sample(16'sh0000);
    send_sample(16'shffff);
    send_sample(16'sh0001);
  endtask

  // window length zero behaves as one
  task automatic test_window_zero();
    write_window(7'd0);
    send_sample(16'sh8000);
    send_sample(16'sh7fff);
    send_sample(16'sh3039);
  endtask

  // short window wraps the ring, negative means truncate toward zero
  task automatic test_short_window_wrap();
    write_window(7'd3);
    repeat (3) send_sample(16'sh7fff);
    repeat (3) send_sample(16'sh8000);
    send_sample(16'sh0001);
    send_sample(16'shffff);
  endtask

  // window length above the ring size saturates
  task automatic test_window_saturate();
    write_window(7'd127);
    send_sample(16'sh8000);
    send_sample(16'sh7fff);
    send_sample(16'shffff);
    send_sample(16'sh0002);
    send_sample(16'shfffd);
    send_sample(16'sh0000);
  endtask

  // full ring of full-scale samples reaches both mean extremes
  task automatic test_full_scale();
    write_window(7'd64);
    repeat (70) send_sample(16'sh7fff);
    repeat (70) send_sample(16'sh8000);
  endtask

  // receiver holds off long enough that the input stalls
  task automatic test_backpressure();
    write_window(7'd5);
    hold_req = 1'b1;
    repeat (20) send_sample(random_sample());
  endtask

  // sender stops until every mean word is back, then resumes
  task automatic test_drain_pause();
    write_window(7'd9);
    repeat (15) send_sample(random_sample());
    drain_means();
    repeat (15) send_sample(random_sample());
  endtask

  // phases over a spread of window settings, extremes first
  task automatic test_random_windows();
    count_t fixed_lens [7];
    count_t len;
    int     items;
    fixed_lens = '{7'd127, 7'd64, 7'd63, 7'd65, 7'd1, 7'd0, 7'd2};
    for (int p = 0; p < 10; p++) begin
      len = (p < 7) ? fixed_lens[p] : count_t'($urandom_range(0, 127));
      idle_on = ($urandom_range(0, 3) != 0);
      write_window(len);
      items = (len >= 60) ? 100 : 80;
      repeat (items) send_sample(random_sample());
    end
  endtask

  // closing stretch with both sides always ready
  task automatic test_steady_stream();
    idle_on = 1'b0;
    write_window(count_t'($urandom_range(1, 64)));
    repeat (100) send_sample(random_sample());
  endtask

  // main sequence
  initial begin
    rst              = 1'b1;
    cfg_wr_en        = 1'b0;
    cfg_wr_data      = '0;
    sample_ch.valid  = 1'b0;
    sample_ch.sample = '0;
    result_ch.ready  = 1'b0;
    failures         = 0;
    idle_on          = 1'b1;
    hold_req         = 1'b0;
    run_left         = 0;
    run_val          = '0;
    window_reg       = 7'd1;
    hist_sum         = '0;
    hist_fill        = '0;
    hist_oldest      = '0;
    foreach (hist_ring[i]) hist_ring[i] = '0;

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    test_reset_window();
    test_window_zero();
    test_short_window_wrap();
    test_window_saturate();
    test_full_scale();
    test_backpressure();
    test_drain_pause();
    test_random_windows();
    test_steady_stream();

    drain_means();
    repeat (SettleWait) @(posedge clk);
    if (failures == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

[sliding_window_moving_average.f]
hdl/smav_pkg.sv
hdl/smav_sample_if.sv
hdl/smav_result_if.sv
hdl/sliding_window_moving_average.sv
tb/sliding_window_moving_average_test.sv
